// ===== rtl/core/sws_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sws_pkg
// Shared types and constants for the signed word sorter: item codes,
// status codes and the state encodings of the control and sort sequencers.
// ----------------------------------------------------------------------------
package sws_pkg;

   // field widths fixed by the item format
   localparam int WORD_W   = 32;
   localparam int POS_W    = 8;
   localparam int STATUS_W = 2;

   // item operation codes
   typedef enum logic {
      OP_LOAD = 1'b0,
      OP_READ = 1'b1
   } op_type;

   // result status codes
   typedef enum logic [STATUS_W-1:0] {
      STATUS_OK       = 2'd0,
      STATUS_EMPTY    = 2'd1,
      STATUS_OVERFLOW = 2'd2
   } status_type;

   // control sequencer of the top level
   typedef enum logic [1:0] {
      TOP_IDLE,
      TOP_READ,
      TOP_SORT
   } top_state_type;

   // sort sequencer
   typedef enum logic [3:0] {
      SRT_IDLE,
      SRT_PIVOT_RD,
      SRT_PIVOT,
      SRT_SCAN_RD,
      SRT_SCAN,
      SRT_SWAP,
      SRT_FIX_RD,
      SRT_FIX,
      SRT_FIX2,
      SRT_SPLIT,
      SRT_POP_RD,
      SRT_POP
   } srt_state_type;

endpackage
`default_nettype wire

// ===== rtl/core/sws_store.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sws_store
// Word memory: one write port and two read ports with registered read data.
// ----------------------------------------------------------------------------
module sws_store
   import sws_pkg::*;
#(
   parameter int  DEPTH = 256,
   localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic                     clock,
   input  wire logic                     we,
   input  wire logic [IDX_W-1:0]         waddr,
   input  wire logic signed [WORD_W-1:0] wdata,
   input  wire logic [IDX_W-1:0]         raddr_a,
   input  wire logic [IDX_W-1:0]         raddr_b,
   output logic signed [WORD_W-1:0]      rdata_a,
   output logic signed [WORD_W-1:0]      rdata_b
);

   logic signed [WORD_W-1:0] mem [DEPTH];
   logic signed [WORD_W-1:0] rdata_a_ff;
   logic signed [WORD_W-1:0] rdata_b_ff;

   // write port
   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
   end

   // registered read ports
   always_ff @(posedge clock) begin
      rdata_a_ff <= mem[raddr_a];
      rdata_b_ff <= mem[raddr_b];
   end

   assign rdata_a = rdata_a_ff;
   assign rdata_b = rdata_b_ff;

endmodule
`default_nettype wire

// ===== rtl/core/sws_stack.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sws_stack
// Range stack of the sort: a memory with its own stack pointer. Popped
// data is registered and appears in the cycle after the pop.
// ----------------------------------------------------------------------------
module sws_stack
   import sws_pkg::*;
#(
   parameter int  DEPTH  = 128,
   parameter int  DATA_W = 16,
   localparam int SA_W   = (DEPTH > 1) ? $clog2(DEPTH) : 1,
   localparam int SP_W   = $clog2(DEPTH + 1)
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              push,
   input  wire logic [DATA_W-1:0] push_data,
   input  wire logic              pop,
   output logic [DATA_W-1:0]      pop_data,
   output logic                   empty
);

   logic [DATA_W-1:0] mem [DEPTH];
   logic [DATA_W-1:0] pop_data_ff;
   logic [SP_W-1:0]   sp_ff;
   logic [SP_W-1:0]   sp_in;
   logic [SP_W-1:0]   sp_dec;
   logic              full;

   assign sp_dec = sp_ff - SP_W'(1);
   assign empty  = (sp_ff == '0);
   assign full   = (sp_ff == SP_W'(DEPTH));

   // stack pointer
   always_comb begin
      sp_in = sp_ff;
      if (push) begin
         sp_in = sp_ff + SP_W'(1);
      end else if (pop) begin
         sp_in = sp_dec;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sp_ff <= '0;
      end else begin
         sp_ff <= sp_in;
      end
   end

   // memory write on push, registered read on pop
   always_ff @(posedge clock) begin
      if (push) begin
         mem[sp_ff[SA_W-1:0]] <= push_data;
      end
      if (pop) begin
         pop_data_ff <= mem[sp_dec[SA_W-1:0]];
      end
   end

   assign pop_data = pop_data_ff;

   // push and pop never coincide
   a_no_push_pop: assert property (@(posedge clock) disable iff (reset)
      !(push && pop))
      else $error("stack push and pop in the same cycle");

   // no pop from an empty stack
   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      pop |-> !empty)
      else $error("stack underflow");

   // pending ranges are disjoint, so the stack never fills
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      push |-> !full)
      else $error("stack overflow");

endmodule
`default_nettype wire

// ===== rtl/core/sws_sorter.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sws_sorter
// In-place quicksort over the word memory: Lomuto partition with the last
// word of a range as pivot, one compare unit reused for every step, and a
// stack of pending ranges. While idle the memory ports belong to the host.
// ----------------------------------------------------------------------------
module sws_sorter
   import sws_pkg::*;
#(
   parameter int  MAX_ELEMENTS = 256,
   localparam int IDX_W        = (MAX_ELEMENTS > 1) ? $clog2(MAX_ELEMENTS) : 1,
   localparam int STACK_DEPTH  = (MAX_ELEMENTS / 2 > 0) ? MAX_ELEMENTS / 2 : 1
) (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     start,
   input  wire logic [IDX_W-1:0]         start_hi,
   output logic                          busy,
   input  wire logic                     host_we,
   input  wire logic [IDX_W-1:0]         host_waddr,
   input  wire logic signed [WORD_W-1:0] host_wdata,
   input  wire logic [IDX_W-1:0]         host_raddr,
   output logic signed [WORD_W-1:0]      host_rdata
);

   localparam int RANGE_W = 2 * IDX_W;

   srt_state_type state_ff, state_in;

   logic [IDX_W-1:0]         lo_ff, lo_in;
   logic [IDX_W-1:0]         hi_ff, hi_in;
   logic [IDX_W-1:0]         i_ff, i_in;
   logic [IDX_W-1:0]         j_ff, j_in;
   logic signed [WORD_W-1:0] pivot_ff, pivot_in;
   logic signed [WORD_W-1:0] tmp_ff, tmp_in;

   // memory port signals
   logic                     mem_we;
   logic [IDX_W-1:0]         mem_waddr;
   logic signed [WORD_W-1:0] mem_wdata;
   logic [IDX_W-1:0]         mem_raddr_a;
   logic [IDX_W-1:0]         mem_raddr_b;
   logic signed [WORD_W-1:0] rd_a;
   logic signed [WORD_W-1:0] rd_b;

   // stack signals
   logic               stk_push;
   logic [RANGE_W-1:0] stk_push_data;
   logic               stk_pop;
   logic [RANGE_W-1:0] stk_pop_data;
   logic               stk_empty;

   // shared compare unit and index arithmetic
   logic             less;
   logic             last_step;
   logic [IDX_W-1:0] j_inc;
   logic [IDX_W-1:0] i_inc;
   logic [IDX_W-1:0] p_dec;
   logic [IDX_W:0]   lsize;
   logic [IDX_W:0]   rsize;
   logic             left_ok;
   logic             right_ok;

   assign less      = (rd_a < pivot_ff);
   assign j_inc     = j_ff + IDX_W'(1);
   assign i_inc     = i_ff + IDX_W'(1);
   assign p_dec     = i_ff - IDX_W'(1);
   assign last_step = (j_inc == hi_ff);
   assign lsize     = {1'b0, i_ff} - {1'b0, lo_ff};
   assign rsize     = {1'b0, hi_ff} - {1'b0, i_ff};
   assign left_ok   = (lsize >= (IDX_W + 1)'(2));
   assign right_ok  = (rsize >= (IDX_W + 1)'(2));

   assign busy       = (state_ff != SRT_IDLE);
   assign host_rdata = rd_a;

   sws_store #(
      .DEPTH (MAX_ELEMENTS)
   ) u_store (
      .clock   (clock),
      .we      (mem_we),
      .waddr   (mem_waddr),
      .wdata   (mem_wdata),
      .raddr_a (mem_raddr_a),
      .raddr_b (mem_raddr_b),
      .rdata_a (rd_a),
      .rdata_b (rd_b)
   );

   sws_stack #(
      .DEPTH  (STACK_DEPTH),
      .DATA_W (RANGE_W)
   ) u_stack (
      .clock     (clock),
      .reset     (reset),
      .push      (stk_push),
      .push_data (stk_push_data),
      .pop       (stk_pop),
      .pop_data  (stk_pop_data),
      .empty     (stk_empty)
   );

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         SRT_IDLE: begin
            if (start) begin
               state_in = SRT_PIVOT_RD;
            end
         end
         SRT_PIVOT_RD: state_in = SRT_PIVOT;
         SRT_PIVOT:    state_in = SRT_SCAN;
         SRT_SCAN_RD:  state_in = SRT_SCAN;
         SRT_SCAN: begin
            if (less) begin
               state_in = SRT_SWAP;
            end else if (last_step) begin
               state_in = SRT_FIX_RD;
            end else begin
               state_in = SRT_SCAN_RD;
            end
         end
         SRT_SWAP: begin
            state_in = last_step ? SRT_FIX_RD : SRT_SCAN_RD;
         end
         SRT_FIX_RD: state_in = SRT_FIX;
         SRT_FIX:    state_in = SRT_FIX2;
         SRT_FIX2:   state_in = SRT_SPLIT;
         SRT_SPLIT: begin
            if (left_ok || right_ok) begin
               state_in = SRT_PIVOT_RD;
            end else if (stk_empty) begin
               state_in = SRT_IDLE;
            end else begin
               state_in = SRT_POP_RD;
            end
         end
         SRT_POP_RD: state_in = SRT_POP;
         SRT_POP:    state_in = SRT_PIVOT_RD;
         default:    state_in = SRT_IDLE;
      endcase
   end

   // datapath control and memory port selection
   always_comb begin
      lo_in         = lo_ff;
      hi_in         = hi_ff;
      i_in          = i_ff;
      j_in          = j_ff;
      pivot_in      = pivot_ff;
      tmp_in        = tmp_ff;
      mem_we        = 1'b0;
      mem_waddr     = i_ff;
      mem_wdata     = rd_a;
      mem_raddr_a   = j_ff;
      mem_raddr_b   = i_ff;
      stk_push      = 1'b0;
      stk_push_data = {lo_ff, p_dec};
      stk_pop       = 1'b0;
      unique case (state_ff)
         SRT_IDLE: begin
            mem_we      = host_we;
            mem_waddr   = host_waddr;
            mem_wdata   = host_wdata;
            mem_raddr_a = host_raddr;
            if (start) begin
               lo_in = '0;
               hi_in = start_hi;
            end
         end
         // fetch the pivot and open the range
         SRT_PIVOT_RD: begin
            mem_raddr_a = hi_ff;
            i_in        = lo_ff;
            j_in        = lo_ff;
         end
         SRT_PIVOT: begin
            pivot_in = rd_a;
         end
         SRT_SCAN_RD: begin
         end
         // compare one word against the pivot, start a swap when smaller
         SRT_SCAN: begin
            if (less) begin
               mem_we    = 1'b1;
               mem_waddr = i_ff;
               mem_wdata = rd_a;
               tmp_in    = rd_b;
            end else begin
               j_in = j_inc;
            end
         end
         SRT_SWAP: begin
            mem_we    = 1'b1;
            mem_waddr = j_ff;
            mem_wdata = tmp_ff;
            i_in      = i_inc;
            j_in      = j_inc;
         end
         // move the pivot to its final place
         SRT_FIX_RD: begin
            mem_raddr_a = i_ff;
         end
         SRT_FIX: begin
            mem_we    = 1'b1;
            mem_waddr = i_ff;
            mem_wdata = pivot_ff;
            tmp_in    = rd_a;
         end
         SRT_FIX2: begin
            mem_we    = 1'b1;
            mem_waddr = hi_ff;
            mem_wdata = tmp_ff;
         end
         // keep a side that needs sorting; when both do, keep the smaller and park the larger on the stack
         SRT_SPLIT: begin
            if (left_ok && right_ok) begin
               stk_push = 1'b1;
               if (lsize < rsize) begin
                  stk_push_data = {i_inc, hi_ff};
                  hi_in         = p_dec;
               end else begin
                  stk_push_data = {lo_ff, p_dec};
                  lo_in         = i_inc;
               end
            end else if (left_ok) begin
               hi_in = p_dec;
            end else if (right_ok) begin
               lo_in = i_inc;
            end
         end
         SRT_POP_RD: begin
            stk_pop = 1'b1;
         end
         SRT_POP: begin
            lo_in = stk_pop_data[RANGE_W-1:IDX_W];
            hi_in = stk_pop_data[IDX_W-1:0];
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= SRT_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      lo_ff    <= lo_in;
      hi_ff    <= hi_in;
      i_ff     <= i_in;
      j_ff     <= j_in;
      pivot_ff <= pivot_in;
      tmp_ff   <= tmp_in;
   end

   // a sort starts only from idle
   a_start_idle: assert property (@(posedge clock) disable iff (reset)
      start |-> (state_ff == SRT_IDLE))
      else $error("sort started while busy");

   // a partitioned range holds at least two words
   a_range_size: assert property (@(posedge clock) disable iff (reset)
      (state_ff == SRT_PIVOT_RD) |-> (lo_ff < hi_ff))
      else $error("partition of a range shorter than two");

   // the boundary never passes the scan index, and the scan stops before the pivot
   a_scan_order: assert property (@(posedge clock) disable iff (reset)
      (state_ff == SRT_SCAN || state_ff == SRT_SCAN_RD || state_ff == SRT_SWAP)
      |-> (lo_ff <= i_ff && i_ff <= j_ff && j_ff < hi_ff))
      else $error("partition indexes out of order");

endmodule
`default_nettype wire

// ===== rtl/core/signed_word_sorter.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// signed_word_sorter
// Collects a set of signed words, sorts it in place in ascending order when
// the closing word arrives, then hands the words out one per read item.
// ----------------------------------------------------------------------------
//  channel  direction  handshake              payload
//  req      in         req_valid / req_stall  operation, value, set_end
//  rsp      out        rsp_valid / rsp_stall  sorted_value, position,
//                                             final_element, status
//
//  a load is written to memory as it is taken; a read goes through the memory read, then the result register
//  a closing load runs the quicksort: each scanned word has a read state and a compare state,
//  a smaller word adds a swap state, and each partition adds the pivot read, pivot fix and split states;
//  ordered data is the worst case
//  the single word memory and its compare unit set the sort time
//  reset clears count, read pointer and sort state; no memory clearing pass
//  an item is taken while a result waits unless rsp_stall holds it
// ----------------------------------------------------------------------------
module signed_word_sorter
   import sws_pkg::*;
#(
   parameter int  MAX_ELEMENTS = 256,
   localparam int IDX_W        = (MAX_ELEMENTS > 1) ? $clog2(MAX_ELEMENTS) : 1,
   localparam int CNT_W        = $clog2(MAX_ELEMENTS + 1)
) (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     req_valid,
   output logic                          req_stall,
   input  wire logic                     req_operation,
   input  wire logic signed [WORD_W-1:0] req_value,
   input  wire logic                     req_set_end,
   output logic                          rsp_valid,
   input  wire logic                     rsp_stall,
   output logic signed [WORD_W-1:0]      rsp_sorted_value,
   output logic [POS_W-1:0]              rsp_position,
   output logic                          rsp_final_element,
   output logic [STATUS_W-1:0]           rsp_status
);

   top_state_type state_ff, state_in;

   logic [CNT_W-1:0]         count_ff, count_in;
   logic [CNT_W-1:0]         rp_ff, rp_in;
   logic                     sorted_ff, sorted_in;
   logic                     rsp_valid_ff, rsp_valid_in;
   logic signed [WORD_W-1:0] rsp_value_ff, rsp_value_in;
   logic [POS_W-1:0]         rsp_pos_ff, rsp_pos_in;
   logic                     rsp_final_ff, rsp_final_in;
   status_type               rsp_status_ff, rsp_status_in;

   logic                     accept;
   logic [CNT_W-1:0]         base;
   logic                     room;
   logic [CNT_W-1:0]         count_new;
   logic [CNT_W-1:0]         rp_inc;
   logic                     read_ok;
   logic                     sort_go;

   logic                     sort_start;
   logic [IDX_W-1:0]         sort_hi;
   logic                     sort_busy;
   logic                     host_we;
   logic [IDX_W-1:0]         host_waddr;
   logic [IDX_W-1:0]         host_raddr;
   logic signed [WORD_W-1:0] host_rdata;

   // handshake
   assign req_stall = (state_ff != TOP_IDLE) || (rsp_valid_ff && rsp_stall);
   assign accept    = req_valid && !req_stall;

   // a load after a closed set starts over at zero
   assign base      = sorted_ff ? '0 : count_ff;
   assign room      = (base < CNT_W'(MAX_ELEMENTS));
   assign count_new = room ? (base + CNT_W'(1)) : base;
   assign rp_inc    = rp_ff + CNT_W'(1);
   assign read_ok   = sorted_ff && (rp_ff < count_ff);
   assign sort_go   = req_set_end && (count_new >= CNT_W'(2));

   assign host_waddr = base[IDX_W-1:0];
   assign host_raddr = rp_ff[IDX_W-1:0];
   assign sort_hi    = IDX_W'(count_new - CNT_W'(1));

   sws_sorter #(
      .MAX_ELEMENTS (MAX_ELEMENTS)
   ) u_sorter (
      .clock      (clock),
      .reset      (reset),
      .start      (sort_start),
      .start_hi   (sort_hi),
      .busy       (sort_busy),
      .host_we    (host_we),
      .host_waddr (host_waddr),
      .host_wdata (req_value),
      .host_raddr (host_raddr),
      .host_rdata (host_rdata)
   );

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         TOP_IDLE: begin
            if (accept) begin
               unique case (op_type'(req_operation))
                  OP_LOAD: begin
                     if (sort_go) begin
                        state_in = TOP_SORT;
                     end
                  end
                  OP_READ: begin
                     if (read_ok) begin
                        state_in = TOP_READ;
                     end
                  end
                  default: state_in = TOP_IDLE;
               endcase
            end
         end
         TOP_READ: state_in = TOP_IDLE;
         TOP_SORT: begin
            if (!sort_busy) begin
               state_in = TOP_IDLE;
            end
         end
         default: state_in = TOP_IDLE;
      endcase
   end

   // set bookkeeping and result register
   always_comb begin
      count_in      = count_ff;
      rp_in         = rp_ff;
      sorted_in     = sorted_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      rsp_value_in  = rsp_value_ff;
      rsp_pos_in    = rsp_pos_ff;
      rsp_final_in  = rsp_final_ff;
      rsp_status_in = rsp_status_ff;
      host_we       = 1'b0;
      sort_start    = 1'b0;
      unique case (state_ff)
         TOP_IDLE: begin
            if (accept) begin
               unique case (op_type'(req_operation))
                  OP_LOAD: begin
                     host_we   = room;
                     count_in  = count_new;
                     sorted_in = 1'b0;
                     rp_in     = '0;
                     if (!room) begin
                        rsp_valid_in  = 1'b1;
                        rsp_value_in  = '0;
                        rsp_pos_in    = '0;
                        rsp_final_in  = 1'b0;
                        rsp_status_in = STATUS_OVERFLOW;
                     end
                     if (req_set_end) begin
                        sorted_in  = 1'b1;
                        sort_start = sort_go;
                     end
                  end
                  OP_READ: begin
                     if (read_ok) begin
                        rsp_pos_in    = POS_W'(rp_ff);
                        rsp_final_in  = (rp_inc == count_ff);
                        rsp_status_in = STATUS_OK;
                        rp_in         = rp_inc;
                     end else begin
                        rsp_valid_in  = 1'b1;
                        rsp_value_in  = '0;
                        rsp_pos_in    = '0;
                        rsp_final_in  = 1'b0;
                        rsp_status_in = STATUS_EMPTY;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         // word from memory arrives in the cycle after the read
         TOP_READ: begin
            rsp_valid_in = 1'b1;
            rsp_value_in = host_rdata;
         end
         TOP_SORT: begin
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= TOP_IDLE;
         count_ff     <= '0;
         rp_ff        <= '0;
         sorted_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rp_ff        <= rp_in;
         sorted_ff    <= sorted_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_value_ff  <= rsp_value_in;
      rsp_pos_ff    <= rsp_pos_in;
      rsp_final_ff  <= rsp_final_in;
      rsp_status_ff <= rsp_status_in;
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_sorted_value  = rsp_value_ff;
   assign rsp_position      = rsp_pos_ff;
   assign rsp_final_element = rsp_final_ff;
   assign rsp_status        = rsp_status_ff;

   // read pointer never runs past the set
   a_rp_bound: assert property (@(posedge clock) disable iff (reset)
      rp_ff <= count_ff)
      else $error("read pointer beyond set size");

   // count stays within capacity
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(MAX_ELEMENTS))
      else $error("element count beyond capacity");

   // a sort runs only on a closed set
   a_sort_closed: assert property (@(posedge clock) disable iff (reset)
      (state_ff == TOP_SORT) |-> sorted_ff)
      else $error("sort running on an open set");

endmodule
`default_nettype wire

// ===== tb/signed_word_sorter_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// signed_word_sorter_checker
// Watches both channels of the sorter and keeps its own copy of the stored
// set. Accepted items update that copy, and any reply they cause is queued.
// Each accepted reply is compared with the oldest queued one, field by field.
// ----------------------------------------------------------------------------
module signed_word_sorter_checker
   import sws_pkg::*;
#(
   parameter int MAX_ELEMENTS = 256
) (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     req_valid,
   input  wire logic                     req_stall,
   input  wire logic                     req_operation,
   input  wire logic signed [WORD_W-1:0] req_value,
   input  wire logic                     req_set_end,
   input  wire logic                     rsp_valid,
   input  wire logic                     rsp_stall,
   input  wire logic signed [WORD_W-1:0] rsp_sorted_value,
   input  wire logic [POS_W-1:0]         rsp_position,
   input  wire logic                     rsp_final_element,
   input  wire logic [STATUS_W-1:0]      rsp_status,
   output int                            mismatches,
   output int                            words_due
);

   typedef struct packed {
      logic signed [WORD_W-1:0] word;
      logic [POS_W-1:0]         rank;
      logic                     last;
      status_type               status;
   } ranked_word_type;

   // replies still owed by the sorter, oldest first
   ranked_word_type          due_words[$];

   // shadow of the stored set
   logic signed [WORD_W-1:0] set_words [MAX_ELEMENTS];
   int                       set_size;
   int                       read_rank;
   bit                       set_closed;

   // update the shadow set for one item; returns 1 when the item owes a reply
   function automatic bit predict_reply(input op_type op,
                                        input logic signed [WORD_W-1:0] word,
                                        input logic set_end,
                                        output ranked_word_type reply);
      logic signed [WORD_W-1:0] key;
      int                       j;
      bit                       dropped;
      reply = '{word: '0, rank: '0, last: 1'b0, status: STATUS_OK};
      dropped = 1'b0;
      if (op == OP_LOAD) begin
         // a load after a closed set opens a fresh one
         if (set_closed) begin
            set_size = 0;
            read_rank = 0;
            set_closed = 1'b0;
         end
         if (set_size < MAX_ELEMENTS) begin
            set_words[set_size] = word;
            set_size++;
         end else begin
            dropped = 1'b1;
         end
         // closing load: ascending order, any stable method gives the same words
         if (set_end) begin
            for (int i = 1; i < set_size; i++) begin
               key = set_words[i];
               j = i;
               while (j > 0 && set_words[j-1] > key) begin
                  set_words[j] = set_words[j-1];
                  j--;
               end
               set_words[j] = key;
            end
            set_closed = 1'b1;
            read_rank = 0;
         end
         if (dropped)
            reply.status = STATUS_OVERFLOW;
         return dropped;
      end
      // read: next word in order, or empty when none is left
      if (set_closed && read_rank < set_size) begin
         reply.word = set_words[read_rank];
         reply.rank = read_rank[POS_W-1:0];
         reply.last = (read_rank + 1 == set_size);
         read_rank++;
      end else begin
         reply.status = STATUS_EMPTY;
      end
      return 1'b1;
   endfunction

   // replies are matched before new items so one edge can retire and add
   always @(posedge clock) begin
      ranked_word_type oldest;
      ranked_word_type fresh;
      if (reset) begin
         set_size = 0;
         read_rank = 0;
         set_closed = 1'b0;
         due_words.delete();
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (due_words.size() == 0) begin
               $display("%0t unexpected reply: word %0d rank %0d last %0b status %0d",
                        $time, rsp_sorted_value, rsp_position, rsp_final_element,
                        rsp_status);
               mismatches++;
            end else begin
               oldest = due_words.pop_front();
               if (rsp_sorted_value !== oldest.word || rsp_position !== oldest.rank ||
                   rsp_final_element !== oldest.last || rsp_status !== oldest.status) begin
                  $display("%0t reply mismatch: expected word %0d rank %0d last %0b status %0d",
                           $time, $signed(oldest.word), oldest.rank, oldest.last,
                           oldest.status);
                  $display("%0t                 actual   word %0d rank %0d last %0b status %0d",
                           $time, rsp_sorted_value, rsp_position, rsp_final_element,
                           rsp_status);
                  mismatches++;
               end
            end
         end
         if (req_valid && !req_stall) begin
            if (predict_reply(op_type'(req_operation), req_value, req_set_end, fresh))
               due_words.push_back(fresh);
         end
      end
      words_due = due_words.size();
   end

endmodule

// ===== tb/signed_word_sorter_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// signed_word_sorter_tb
// Drives the sorter with directed sets (extreme words, duplicates, a single
// word set, reads on an empty or open set), then random sets of loads and
// read-backs, one of them filled to capacity and overrun. Both channels idle
// at random. The checker beside the block predicts and compares every reply.
// ----------------------------------------------------------------------------
module signed_word_sorter_tb;
   import sws_pkg::*;

   localparam int MAX_ELEMENTS  = 256;
   localparam int RANDOM_ITEMS  = 750;
   localparam int SMALL_SET_MAX = 20;
   localparam int RUN_LIMIT_NS  = 1_000_000;

   localparam logic signed [WORD_W-1:0] WORD_MIN = {1'b1, {(WORD_W-1){1'b0}}};
   localparam logic signed [WORD_W-1:0] WORD_MAX = {1'b0, {(WORD_W-1){1'b1}}};

   logic                     clock = 1'b0;
   logic                     reset;
   logic                     req_valid;
   logic                     req_stall;
   logic                     req_operation;
   logic signed [WORD_W-1:0] req_value;
   logic                     req_set_end;
   logic                     rsp_valid;
   logic                     rsp_stall;
   logic signed [WORD_W-1:0] rsp_sorted_value;
   logic [POS_W-1:0]         rsp_position;
   logic                     rsp_final_element;
   logic [STATUS_W-1:0]      rsp_status;

   int mismatches;
   int words_due;
   int items_sent;
   bit calm;

   always #1 clock = ~clock;

   signed_word_sorter #(
      .MAX_ELEMENTS(MAX_ELEMENTS)
   ) DUT (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_operation    (req_operation),
      .req_value        (req_value),
      .req_set_end      (req_set_end),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_sorted_value (rsp_sorted_value),
      .rsp_position     (rsp_position),
      .rsp_final_element(rsp_final_element),
      .rsp_status       (rsp_status)
   );

   signed_word_sorter_checker #(
      .MAX_ELEMENTS(MAX_ELEMENTS)
   ) u_checker (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_operation    (req_operation),
      .req_value        (req_value),
      .req_set_end      (req_set_end),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_sorted_value (rsp_sorted_value),
      .rsp_position     (rsp_position),
      .rsp_final_element(rsp_final_element),
      .rsp_status       (rsp_status),
      .mismatches       (mismatches),
      .words_due        (words_due)
   );

   // receiver stalls now and then, never during the calm stretch
   always @(posedge clock) begin
      rsp_stall <= !calm && ($urandom_range(99) < 7);
   end

   // present one item, with an occasional gap before it, and wait until taken
   task automatic send_item(input op_type op, input logic signed [WORD_W-1:0] word,
                            input logic set_end);
      calm = (items_sent >= 80 && items_sent < 230);
      if (!calm && $urandom_range(99) < 7) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 3)) @(posedge clock);
      end
      req_valid     <= 1'b1;
      req_operation <= op;
      req_value     <= word;
      req_set_end   <= set_end;
      do @(posedge clock); while (req_stall);
      items_sent++;
   endtask

   initial begin
      int                       set_size;
      int                       style;
      int                       reads;
      int                       set_index;
      int                       step;
      bit                       full;
      logic signed [WORD_W-1:0] word;
      logic signed [WORD_W-1:0] base;

      reset         <= 1'b1;
      req_valid     <= 1'b0;
      req_operation <= OP_LOAD;
      req_value     <= '0;
      req_set_end   <= 1'b0;
      items_sent    = 0;
      calm          = 1'b0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // read with nothing loaded
      send_item(OP_READ, '0, 1'b0);
      // extremes, zero, minus one and a duplicate, then read past the end
      send_item(OP_LOAD, WORD_MAX, 1'b0);
      send_item(OP_LOAD, WORD_MIN, 1'b0);
      send_item(OP_LOAD, '0, 1'b0);
      send_item(OP_LOAD, -1, 1'b0);
      send_item(OP_LOAD, 1, 1'b0);
      send_item(OP_LOAD, WORD_MIN, 1'b1);
      repeat (7) send_item(OP_READ, $urandom, 1'b1);
      // one word set
      send_item(OP_LOAD, 42, 1'b1);
      repeat (2) send_item(OP_READ, $urandom, 1'b0);
      // new set started after the one word set was read, read while still open
      send_item(OP_LOAD, 5, 1'b0);
      send_item(OP_READ, $urandom, 1'b1);
      send_item(OP_LOAD, -3, 1'b1);
      send_item(OP_READ, $urandom, 1'b0);

      // random sets; the third one fills the store and overruns it
      items_sent = 0;
      set_index  = 0;
      while (items_sent < RANDOM_ITEMS) begin
         full     = (set_index == 2);
         set_size = full ? MAX_ELEMENTS : $urandom_range(1, SMALL_SET_MAX);
         style    = full ? 0 : $urandom_range(0, 4);
         base     = $urandom;
         step     = $urandom_range(1, 1000);
         for (int k = 0; k < set_size; k++) begin
            // stray read into a set that is still open
            if (!full && $urandom_range(99) < 5)
               send_item(OP_READ, $urandom, 1'($urandom));
            case (style)
               0: word = $urandom;
               1: word = $signed($urandom_range(0, 6)) - 3;
               2: word = base + k * step;
               3: word = base - k * step;
               default: begin
                  case ($urandom_range(0, 4))
                     0: word = WORD_MIN;
                     1: word = WORD_MAX;
                     2: word = '0;
                     3: word = -1;
                     default: word = $urandom;
                  endcase
               end
            endcase
            send_item(OP_LOAD, word, full ? 1'b0 : (k == set_size - 1));
         end
         // overrun: one dropped word, then a dropped word that closes the set
         if (full) begin
            send_item(OP_LOAD, $urandom, 1'b0);
            send_item(OP_LOAD, $urandom, 1'b1);
         end
         // read back the whole set, part of it, or past its end
         case ($urandom_range(0, 9))
            0: reads = $urandom_range(0, set_size - 1);
            1: reads = set_size + $urandom_range(1, 3);
            default: reads = set_size;
         endcase
         if (full)
            reads = set_size + 1;
         repeat (reads) send_item(OP_READ, $urandom, 1'($urandom));
         set_index++;
      end
      req_valid <= 1'b0;

      // drain, then allow for late or extra replies
      do @(negedge clock); while (words_due != 0);
      repeat (50) @(negedge clock);
      if (mismatches == 0 && words_due == 0)
         $display("[ OK ] regression clean");
      else
         $display("[FAIL] regression broken");
      $finish;
   end

   // hang guard
   initial begin
      #(RUN_LIMIT_NS);
      $display("[FAIL] regression broken");
      $finish;
   end

endmodule
